>>> sv/pvd_pkg.sv
package pvd_pkg;

    // Input word layout
    localparam int IN_W       = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Serial multiplier: MUL_AW-bit multiplicand, MUL_BW multiplier bits, one per cycle
    localparam int MUL_AW = 16;
    localparam int MUL_BW = 12;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW + 1);

    // Serial divider: one quotient bit per cycle
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 12;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Width of the running P+I+D sum, 1/256 units
    localparam int SUM_W = 34;

    localparam logic [DIV_DW-1:0] DERIV_DIV   = 12'd50;
    localparam logic [DIV_DW-1:0] TOTAL_LIMIT = 12'd2300;

    // Cut directions
    localparam logic [1:0] DIR_RAISE   = 2'd0;
    localparam logic [1:0] DIR_LOWER   = 2'd1;
    localparam logic [1:0] DIR_NEUTRAL = 2'd2;
    localparam logic [1:0] DIR_NONE    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRACT_START = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTEND_START  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FLOOR    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_CEILING  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 4'd7;

    // Register reset values
    localparam logic [7:0]  RST_GAIN_PROP     = 8'd35;
    localparam logic [15:0] RST_GAIN_INTEG    = 16'd5;
    localparam logic [14:0] RST_GAIN_DERIV    = 15'd3100;
    localparam logic [11:0] RST_RETRACT_START = 12'd1845;
    localparam logic [11:0] RST_EXTEND_START  = 12'd2250;
    localparam logic [11:0] RST_CODE_FLOOR    = 12'd450;
    localparam logic [11:0] RST_CODE_CEILING  = 12'd3645;
    localparam logic [7:0]  RST_DEAD_ZONE     = 8'd2;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [MUL_PW-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_D,
        ST_TOTAL,
        ST_MUL_M,
        ST_DIV_M,
        ST_CLAMP,
        ST_PUT
    } state_t;

endpackage

>>> sv/pvd_smul.sv
// Shift-add multiplier, one multiplier bit per cycle, unsigned operands
module pvd_smul (
    input  logic               clk,
    input  logic               rst_n,
    input  pvd_pkg::mul_req_t  req,
    output pvd_pkg::mul_rsp_t  rsp
);

    logic [pvd_pkg::MUL_PW-1:0] prod_reg, prod_next;
    logic [pvd_pkg::MUL_AW-1:0] a_reg, a_next;
    logic [pvd_pkg::MUL_CW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pvd_pkg::MUL_AW:0]   part_sum;

    // Upper half plus multiplicand when the low bit is set
    always_comb
    begin
        part_sum = {1'b0, prod_reg[pvd_pkg::MUL_PW-1:pvd_pkg::MUL_BW]}
                 + (prod_reg[0] ? {1'b0, a_reg} : '0);
    end

    always_comb
    begin
        prod_next = prod_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            prod_next = {{pvd_pkg::MUL_AW{1'b0}}, req.b};
            a_next    = req.a;
            cnt_next  = pvd_pkg::MUL_CW'(pvd_pkg::MUL_BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {part_sum, prod_reg[pvd_pkg::MUL_BW-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != pvd_pkg::MUL_CW'(1));
            done_next = (cnt_reg == pvd_pkg::MUL_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

endmodule

>>> sv/pvd_sdiv.sv
// Restoring divider, one quotient bit per cycle, unsigned, truncating
module pvd_sdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  pvd_pkg::div_req_t  req,
    output pvd_pkg::div_rsp_t  rsp
);

    logic [pvd_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [pvd_pkg::DIV_NW-1:0] quot_reg, quot_next;
    logic [pvd_pkg::DIV_DW-1:0] dvs_reg, dvs_next;
    logic [pvd_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pvd_pkg::DIV_DW:0]   shifted;
    logic [pvd_pkg::DIV_DW:0]   trial;
    logic                       fits;

    // Bring down the next dividend bit and try the subtract
    always_comb
    begin
        shifted = {rem_reg, quot_reg[pvd_pkg::DIV_NW-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quot_next = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = pvd_pkg::DIV_CW'(pvd_pkg::DIV_NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[pvd_pkg::DIV_DW-1:0] : shifted[pvd_pkg::DIV_DW-1:0];
            quot_next = {quot_reg[pvd_pkg::DIV_NW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != pvd_pkg::DIV_CW'(1));
            done_next = (cnt_reg == pvd_pkg::DIV_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> sv/pid_valve_drive.sv
// PID valve driver with an error deadband.
// s_axis carries one control tick per word: cut direction, cut magnitude, auto flag.
// m_axis returns one word per tick: the valve DAC code and a loop-active flag.
// cfg_* writes the gain, code-range and deadband registers by index; cfg_ready is
// always high, and writes belong between ticks while no result is outstanding.
// Paths, acceptance to m_axis_tvalid:
//   auto off or direction 3: ST_PUT only (float code, loop_active 0, state held)
//   neutral: P, I, D products, D quotient; raise or lower: plus map product, quotient
//   cut outside the deadband skips the integral product
// The block takes one tick at a time and is ready again the cycle after its
// result enters the output register. The path length is set by the shared serial
// multiplier (up to four products per tick) and the shared serial divider (up to two
// quotients per tick).
// Reset loads the register defaults and clears the integrator and last error.
// A stalled receiver holds the output word; the next tick is accepted meanwhile
// and waits in its last step until the output register frees.
module pid_valve_drive #(
    parameter int DAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] cut_dir, [9:2] cut_size, [10] auto_on
    input  logic [pvd_pkg::IN_W-1:0]              s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [DAC_BITS-1:0] dac_code, [DAC_BITS] loop_active
    output logic [((DAC_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pvd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pvd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int OUT_W = ((DAC_BITS + 8) / 8) * 8;
    // Code width: holds -4095..8190 and the float code
    localparam int CW = (DAC_BITS > 13) ? DAC_BITS + 1 : 15;
    localparam logic signed [CW-1:0] FLOAT_CODE = $signed(CW'(1) << (DAC_BITS - 1));

    // Configuration registers
    logic [7:0]  gain_prop_reg;
    logic [15:0] gain_integ_reg;
    logic [14:0] gain_deriv_reg;
    logic [11:0] retract_reg;
    logic [11:0] extend_reg;
    logic [11:0] floor_reg;
    logic [11:0] ceil_reg;
    logic [7:0]  dead_zone_reg;

    // Sequencer and loop state
    pvd_pkg::state_t state_reg, state_next;
    logic signed [31:0] integ_acc_reg, integ_acc_next;
    logic signed [8:0]  prev_error_reg, prev_error_next;

    // Per-tick working registers
    logic [1:0]                     dir_reg, dir_next;
    // Magnitude of the error, kept from acceptance for the integral product
    logic [7:0]                     size_reg, size_next;
    logic                           neg_e_reg, neg_e_next;
    logic                           inband_reg, inband_next;
    logic                           d_neg_reg, d_neg_next;
    logic [9:0]                     d_mag_reg, d_mag_next;
    logic signed [pvd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                           map_neg_reg, map_neg_next;
    logic signed [CW-1:0]           code_reg, code_next;
    logic                           active_reg, active_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [DAC_BITS-1:0] out_code_reg, out_code_next;
    logic                out_active_reg, out_active_next;

    pvd_pkg::mul_req_t mul_req;
    pvd_pkg::mul_rsp_t mul_rsp;
    pvd_pkg::div_req_t div_req;
    pvd_pkg::div_rsp_t div_rsp;

    logic [1:0]  in_dir;
    logic [7:0]  in_size;
    logic        in_auto;
    logic        in_run;
    logic        accept;
    logic        out_load;

    logic signed [8:0]  e_val;
    logic signed [9:0]  d_val;
    logic [9:0]         d_abs;

    logic [pvd_pkg::SUM_W-1:0] sum_abs;
    logic [pvd_pkg::SUM_W-9:0] sum_shift;
    logic [11:0]               total_mag;
    logic signed [12:0]        span;
    logic [12:0]               span_abs;

    logic [pvd_pkg::SUM_W-1:0]       p_term;
    logic [pvd_pkg::SUM_W-1:0]       i_term;
    logic [pvd_pkg::SUM_W-1:0]       d_term;
    logic signed [pvd_pkg::SUM_W-1:0] integ_sum;
    logic signed [CW-1:0]            base_s;
    logic signed [CW-1:0]            q_s;
    logic signed [CW-1:0]            ceil_s;
    logic signed [CW-1:0]            floor_s;
    logic signed [CW-1:0]            clamp_code;

    pvd_smul u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pvd_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Input word fields
    assign in_dir  = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[9:2];
    assign in_auto = s_axis_tdata[10];
    assign in_run  = in_auto && (in_dir != pvd_pkg::DIR_NONE);
    assign accept  = s_axis_tvalid && s_axis_tready;

    // Error and error step
    always_comb
    begin
        e_val = (in_dir == pvd_pkg::DIR_RAISE) ? $signed({1'b0, in_size})
                                               : -$signed({1'b0, in_size});
        d_val = {e_val[8], e_val} - {prev_error_reg[8], prev_error_reg};
        d_abs = d_val[9] ? (10'd0 - d_val) : d_val;
    end

    // Total magnitude, clamped, and the code span of the active direction
    always_comb
    begin
        sum_abs   = sum_reg[pvd_pkg::SUM_W-1] ? (pvd_pkg::SUM_W'(0) - sum_reg) : sum_reg;
        sum_shift = sum_abs[pvd_pkg::SUM_W-1:8];
        if (sum_shift > (pvd_pkg::SUM_W - 8)'(pvd_pkg::TOTAL_LIMIT))
        begin
            total_mag = pvd_pkg::TOTAL_LIMIT;
        end
        else
        begin
            total_mag = sum_shift[11:0];
        end
        if (dir_reg == pvd_pkg::DIR_LOWER)
        begin
            span = $signed({1'b0, floor_reg}) - $signed({1'b0, retract_reg});
        end
        else
        begin
            span = $signed({1'b0, ceil_reg}) - $signed({1'b0, extend_reg});
        end
        span_abs = span[12] ? (13'd0 - span) : span;
    end

    // Sum terms and integrator update
    always_comb
    begin
        p_term = {{(pvd_pkg::SUM_W - 24){1'b0}}, mul_rsp.prod[15:0], 8'd0};
        i_term = {{(pvd_pkg::SUM_W - 24){1'b0}}, mul_rsp.prod[23:0]};
        d_term = {{(pvd_pkg::SUM_W - pvd_pkg::DIV_NW){1'b0}}, div_rsp.quot};
        integ_sum = {{(pvd_pkg::SUM_W - 32){integ_acc_reg[31]}}, integ_acc_reg}
                  + (neg_e_reg ? (pvd_pkg::SUM_W'(0) - i_term) : i_term);
    end

    // Code from the map quotient, and the limit checks
    always_comb
    begin
        base_s  = (dir_reg == pvd_pkg::DIR_LOWER) ? $signed(CW'(retract_reg))
                                                   : $signed(CW'(extend_reg));
        q_s     = $signed(CW'(div_rsp.quot[11:0]));
        ceil_s  = $signed(CW'(ceil_reg));
        floor_s = $signed(CW'(floor_reg));
        clamp_code = code_reg;
        if (clamp_code >= ceil_s)
        begin
            clamp_code = ceil_s;
        end
        if (clamp_code <= floor_s)
        begin
            clamp_code = floor_s;
        end
        if (inband_reg)
        begin
            clamp_code = FLOAT_CODE;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pvd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_run ? pvd_pkg::ST_MUL_P : pvd_pkg::ST_PUT;
                end
            end
            pvd_pkg::ST_MUL_P:
            begin
                if (mul_rsp.done)
                begin
                    state_next = inband_reg ? pvd_pkg::ST_MUL_I : pvd_pkg::ST_MUL_D;
                end
            end
            pvd_pkg::ST_MUL_I:
            begin
                if (mul_rsp.done)
                begin
                    state_next = pvd_pkg::ST_MUL_D;
                end
            end
            pvd_pkg::ST_MUL_D:
            begin
                if (mul_rsp.done)
                begin
                    state_next = pvd_pkg::ST_DIV_D;
                end
            end
            pvd_pkg::ST_DIV_D:
            begin
                if (div_rsp.done)
                begin
                    state_next = pvd_pkg::ST_TOTAL;
                end
            end
            pvd_pkg::ST_TOTAL:
            begin
                state_next = (dir_reg == pvd_pkg::DIR_NEUTRAL) ? pvd_pkg::ST_CLAMP
                                                                : pvd_pkg::ST_MUL_M;
            end
            pvd_pkg::ST_MUL_M:
            begin
                if (mul_rsp.done)
                begin
                    state_next = pvd_pkg::ST_DIV_M;
                end
            end
            pvd_pkg::ST_DIV_M:
            begin
                if (div_rsp.done)
                begin
                    state_next = pvd_pkg::ST_CLAMP;
                end
            end
            pvd_pkg::ST_CLAMP:
            begin
                state_next = pvd_pkg::ST_PUT;
            end
            pvd_pkg::ST_PUT:
            begin
                if (out_load)
                begin
                    state_next = pvd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pvd_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshakes and arithmetic unit launches
    always_comb
    begin
        s_axis_tready    = (state_reg == pvd_pkg::ST_IDLE);
        cfg_ready        = 1'b1;
        out_load         = (state_reg == pvd_pkg::ST_PUT) && (!out_valid_reg || m_axis_tready);
        mul_req          = '0;
        div_req          = '0;
        div_req.divisor  = pvd_pkg::DERIV_DIV;
        unique case (state_reg)
            pvd_pkg::ST_IDLE:
            begin
                mul_req.start = accept && in_run;
                mul_req.a     = pvd_pkg::MUL_AW'(gain_prop_reg);
                mul_req.b     = pvd_pkg::MUL_BW'(in_size);
            end
            pvd_pkg::ST_MUL_P:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = inband_reg ? gain_integ_reg : pvd_pkg::MUL_AW'(gain_deriv_reg);
                mul_req.b     = inband_reg ? pvd_pkg::MUL_BW'(size_reg)
                                           : pvd_pkg::MUL_BW'(d_mag_reg);
            end
            pvd_pkg::ST_MUL_I:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = pvd_pkg::MUL_AW'(gain_deriv_reg);
                mul_req.b     = pvd_pkg::MUL_BW'(d_mag_reg);
            end
            pvd_pkg::ST_MUL_D:
            begin
                div_req.start    = mul_rsp.done;
                div_req.dividend = {mul_rsp.prod[24:0], 8'd0};
                div_req.divisor  = pvd_pkg::DERIV_DIV;
            end
            pvd_pkg::ST_TOTAL:
            begin
                mul_req.start = (dir_reg != pvd_pkg::DIR_NEUTRAL);
                mul_req.a     = pvd_pkg::MUL_AW'(span_abs[11:0]);
                mul_req.b     = total_mag;
            end
            pvd_pkg::ST_MUL_M:
            begin
                div_req.start    = mul_rsp.done;
                div_req.dividend = pvd_pkg::DIV_NW'(mul_rsp.prod[23:0]);
                div_req.divisor  = pvd_pkg::TOTAL_LIMIT;
            end
            pvd_pkg::ST_DIV_D,
            pvd_pkg::ST_DIV_M,
            pvd_pkg::ST_CLAMP,
            pvd_pkg::ST_PUT:
            begin
                mul_req = '0;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        dir_next        = dir_reg;
        size_next       = size_reg;
        neg_e_next      = neg_e_reg;
        inband_next     = inband_reg;
        d_neg_next      = d_neg_reg;
        d_mag_next      = d_mag_reg;
        sum_next        = sum_reg;
        map_neg_next    = map_neg_reg;
        code_next       = code_reg;
        active_next     = active_reg;
        integ_acc_next  = integ_acc_reg;
        prev_error_next = prev_error_reg;
        unique case (state_reg)
            pvd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dir_next    = in_dir;
                    size_next   = in_size;
                    inband_next = (in_size < dead_zone_reg);
                    code_next   = FLOAT_CODE;
                    active_next = 1'b0;
                    if (in_run)
                    begin
                        neg_e_next      = (in_dir != pvd_pkg::DIR_RAISE);
                        d_neg_next      = d_val[9];
                        d_mag_next      = d_abs;
                        prev_error_next = e_val;
                        sum_next        = '0;
                    end
                end
            end
            pvd_pkg::ST_MUL_P:
            begin
                if (mul_rsp.done)
                begin
                    sum_next = neg_e_reg ? $signed(pvd_pkg::SUM_W'(0) - p_term)
                                         : $signed(p_term);
                    if (!inband_reg)
                    begin
                        integ_acc_next = '0;
                    end
                end
            end
            pvd_pkg::ST_MUL_I:
            begin
                if (mul_rsp.done)
                begin
                    // Saturate to the signed 32-bit range
                    if ((integ_sum[pvd_pkg::SUM_W-1:31] == '0) ||
                        (integ_sum[pvd_pkg::SUM_W-1:31] == '1))
                    begin
                        integ_acc_next = integ_sum[31:0];
                    end
                    else if (integ_sum[pvd_pkg::SUM_W-1])
                    begin
                        integ_acc_next = 32'sh8000_0000;
                    end
                    else
                    begin
                        integ_acc_next = 32'sh7FFF_FFFF;
                    end
                end
            end
            pvd_pkg::ST_MUL_D:
            begin
                if (mul_rsp.done)
                begin
                    sum_next = sum_reg
                             + {{(pvd_pkg::SUM_W - 32){integ_acc_reg[31]}}, integ_acc_reg};
                end
            end
            pvd_pkg::ST_DIV_D:
            begin
                if (div_rsp.done)
                begin
                    sum_next = d_neg_reg ? (sum_reg - $signed(d_term))
                                         : (sum_reg + $signed(d_term));
                end
            end
            pvd_pkg::ST_TOTAL:
            begin
                map_neg_next = sum_reg[pvd_pkg::SUM_W-1] ^ span[12]
                             ^ (dir_reg == pvd_pkg::DIR_LOWER);
                code_next    = FLOAT_CODE;
            end
            pvd_pkg::ST_DIV_M:
            begin
                if (div_rsp.done)
                begin
                    code_next = map_neg_reg ? (base_s - q_s) : (base_s + q_s);
                end
            end
            pvd_pkg::ST_CLAMP:
            begin
                code_next   = clamp_code;
                active_next = 1'b1;
            end
            default:
            begin
                code_next = code_reg;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_active_next = out_active_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_code_next   = code_reg[DAC_BITS-1:0];
            out_active_next = active_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_active_reg, out_code_reg});

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pvd_pkg::ST_IDLE;
            integ_acc_reg  <= '0;
            prev_error_reg <= '0;
            out_valid_reg  <= 1'b0;
            gain_prop_reg  <= pvd_pkg::RST_GAIN_PROP;
            gain_integ_reg <= pvd_pkg::RST_GAIN_INTEG;
            gain_deriv_reg <= pvd_pkg::RST_GAIN_DERIV;
            retract_reg    <= pvd_pkg::RST_RETRACT_START;
            extend_reg     <= pvd_pkg::RST_EXTEND_START;
            floor_reg      <= pvd_pkg::RST_CODE_FLOOR;
            ceil_reg       <= pvd_pkg::RST_CODE_CEILING;
            dead_zone_reg  <= pvd_pkg::RST_DEAD_ZONE;
        end
        else
        begin
            state_reg      <= state_next;
            integ_acc_reg  <= integ_acc_next;
            prev_error_reg <= prev_error_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pvd_pkg::REG_GAIN_PROP:     gain_prop_reg  <= cfg_data[7:0];
                    pvd_pkg::REG_GAIN_INTEG:    gain_integ_reg <= cfg_data[15:0];
                    pvd_pkg::REG_GAIN_DERIV:    gain_deriv_reg <= cfg_data[14:0];
                    pvd_pkg::REG_RETRACT_START: retract_reg    <= cfg_data[11:0];
                    pvd_pkg::REG_EXTEND_START:  extend_reg     <= cfg_data[11:0];
                    pvd_pkg::REG_CODE_FLOOR:    floor_reg      <= cfg_data[11:0];
                    pvd_pkg::REG_CODE_CEILING:  ceil_reg       <= cfg_data[11:0];
                    pvd_pkg::REG_DEAD_ZONE:     dead_zone_reg  <= cfg_data[7:0];
                    default:
                    begin
                        gain_prop_reg <= gain_prop_reg;
                    end
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        dir_reg        <= dir_next;
        size_reg       <= size_next;
        neg_e_reg      <= neg_e_next;
        inband_reg     <= inband_next;
        d_neg_reg      <= d_neg_next;
        d_mag_reg      <= d_mag_next;
        sum_reg        <= sum_next;
        map_neg_reg    <= map_neg_next;
        code_reg       <= code_next;
        active_reg     <= active_next;
        out_code_reg   <= out_code_next;
        out_active_reg <= out_active_next;
    end

endmodule

>>> tb/pid_valve_drive_test.sv
`timescale 1ns / 100ps

module pid_valve_drive_test;

    localparam int DAC_W = 12;
    localparam int OUT_W = ((DAC_W + 8) / 8) * 8;
    localparam logic [DAC_W-1:0] FLOAT_CODE = 1 << (DAC_W - 1);
    localparam longint ACC_MAX = 2147483647;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int PHASE_COUNT = 8;

    // One control tick; packs straight into s_axis_tdata, cut_dir lowest
    typedef struct packed {
        logic       auto_on;
        logic [7:0] cut_size;
        logic [1:0] cut_dir;
    } tick_t;

    typedef struct packed {
        logic             loop_active;
        logic [DAC_W-1:0] dac_code;
    } drive_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pvd_pkg::IN_W-1:0]       s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [OUT_W-1:0]               m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pvd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pvd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Register copy and loop state of the predictor
    logic [7:0]  gain_p = pvd_pkg::RST_GAIN_PROP;
    logic [15:0] gain_i = pvd_pkg::RST_GAIN_INTEG;
    logic [14:0] gain_d = pvd_pkg::RST_GAIN_DERIV;
    logic [11:0] retract_at = pvd_pkg::RST_RETRACT_START;
    logic [11:0] extend_at = pvd_pkg::RST_EXTEND_START;
    logic [11:0] floor_code = pvd_pkg::RST_CODE_FLOOR;
    logic [11:0] ceil_code = pvd_pkg::RST_CODE_CEILING;
    logic [7:0]  band = pvd_pkg::RST_DEAD_ZONE;
    int          integ_sum = 0;
    int          last_error = 0;

    tick_t       tick_queue[$];
    drive_word_t drive_expect[$];
    tick_t       tick_on_bus;
    int          fault_count = 0;

    // Stimulus shaping
    int          max_run = 8;
    int          run_left = 0;
    logic [1:0]  run_dir = pvd_pkg::DIR_RAISE;

    pid_valve_drive #(
        .DAC_BITS(DAC_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Register write as the block sees it; out-of-range indexes drop
    function automatic void store_reg(input logic [pvd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [pvd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            pvd_pkg::REG_GAIN_PROP:     gain_p = val[7:0];
            pvd_pkg::REG_GAIN_INTEG:    gain_i = val[15:0];
            pvd_pkg::REG_GAIN_DERIV:    gain_d = val[14:0];
            pvd_pkg::REG_RETRACT_START: retract_at = val[11:0];
            pvd_pkg::REG_EXTEND_START:  extend_at = val[11:0];
            pvd_pkg::REG_CODE_FLOOR:    floor_code = val[11:0];
            pvd_pkg::REG_CODE_CEILING:  ceil_code = val[11:0];
            pvd_pkg::REG_DEAD_ZONE:     band = val[7:0];
            default: ;
        endcase
    endfunction

    // Valve word for one tick; advances integrator and last error
    function automatic drive_word_t predict_drive(input tick_t t);
        drive_word_t r;
        longint e, kp, ki, kd, p, d, acc, sum, total, code, dz, lim, div_d;
        longint rs, es, fl, cl;
        r.loop_active = 1'b0;
        r.dac_code = FLOAT_CODE;
        if (!t.auto_on || t.cut_dir == pvd_pkg::DIR_NONE)
            return r;

        e = longint'(t.cut_size);
        if (t.cut_dir != pvd_pkg::DIR_RAISE)
            e = -e;
        kp = longint'(gain_p);
        ki = longint'(gain_i);
        kd = longint'(gain_d);
        dz = longint'(band);
        rs = longint'(retract_at);
        es = longint'(extend_at);
        fl = longint'(floor_code);
        cl = longint'(ceil_code);
        lim = longint'(pvd_pkg::TOTAL_LIMIT);
        div_d = longint'(pvd_pkg::DERIV_DIV);

        p = kp * e * 256;
        d = (kd * (e - last_error) * 256) / div_d;

        // integrator only runs inside the deadband, saturating
        if (-dz < e && e < dz)
        begin
            acc = integ_sum + ki * e;
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            if (acc < ACC_MIN)
                acc = ACC_MIN;
            integ_sum = int'(acc);
        end
        else
            integ_sum = 0;

        sum = p + integ_sum + d;
        total = sum / 256;
        if (total > lim)
            total = lim;
        if (total < -lim)
            total = -lim;

        case (t.cut_dir)
            pvd_pkg::DIR_LOWER: code = rs + (total * (fl - rs)) / (-lim);
            pvd_pkg::DIR_RAISE: code = es + (total * (cl - es)) / lim;
            default:            code = longint'(FLOAT_CODE);
        endcase

        // ceiling first, floor last so it wins when the two cross
        if (code >= cl)
            code = cl;
        if (code <= fl)
            code = fl;
        if (longint'(t.cut_size) < dz)
            code = longint'(FLOAT_CODE);

        last_error = int'(e);
        r.dac_code = code[DAC_W-1:0];
        r.loop_active = 1'b1;
        return r;
    endfunction

    function automatic void add_tick(input logic [1:0] dir, input int size, input logic on);
        tick_t t;
        t.cut_dir = dir;
        t.cut_size = size[7:0];
        t.auto_on = on;
        tick_queue.push_back(t);
    endfunction

    // Random tick: direction held over runs, sizes clustered round the deadband
    function automatic tick_t make_tick();
        tick_t t;
        int    s;
        if (run_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_dir = pvd_pkg::DIR_RAISE;
                4, 5, 6, 7: run_dir = pvd_pkg::DIR_LOWER;
                8:          run_dir = pvd_pkg::DIR_NEUTRAL;
                default:    run_dir = pvd_pkg::DIR_NONE;
            endcase
            run_left = int'($urandom_range(1, max_run));
        end
        run_left--;

        case ($urandom_range(0, 7))
            0:
            begin
                s = int'(band) + int'($urandom_range(0, 2)) - 1;
                if (s < 0)
                    s = 0;
                if (s > 255)
                    s = 255;
            end
            1, 2:    s = (band == 0) ? int'($urandom_range(0, 255))
                                     : int'($urandom_range(0, band - 1));
            3:       s = $urandom_range(0, 1) ? 255 : 0;
            default: s = int'($urandom_range(0, 255));
        endcase

        t.cut_dir = run_dir;
        if ($urandom_range(0, 24) == 0)
            t.cut_dir = pvd_pkg::DIR_NONE;
        t.cut_size = s[7:0];
        t.auto_on = ($urandom_range(0, 19) != 0);
        return t;
    endfunction

    // Wait at a falling edge until no tick is pending or in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || drive_expect.size() != 0);
    endtask

    task automatic write_reg(input logic [pvd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pvd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        store_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Register settings per phase; unused upper data bits carry junk
    task automatic setup_phase(input int ph);
        logic [7:0]  kp, dz;
        logic [15:0] ki, junk;
        logic [14:0] kd;
        logic [11:0] rs, es, fl, cl;
        case (ph)
            0:
            begin
                // gains high, full code range, deadband wide open: integrator winds up
                kp = 255; ki = 16'hFFFF; kd = 25500; dz = 255;
                rs = 4095; es = 0; fl = 0; cl = 4095;
                max_run = 200;
            end
            1:
            begin
                kp = 0; ki = 0; kd = 0; dz = 0;
                rs = 0; es = 0; fl = 0; cl = 0;
                max_run = 6;
            end
            2:
            begin
                // floor above ceiling
                kp = 20; ki = 5; kd = 3100; dz = 3;
                rs = 2000; es = 2100; fl = 3200; cl = 900;
                max_run = 10;
            end
            3:
            begin
                kp = 1; ki = 256; kd = 50; dz = 0;
                rs = 1845; es = 2250; fl = 450; cl = 3645;
                max_run = 4;
            end
            default:
            begin
                kp = 8'($urandom_range(0, 255));
                ki = 16'($urandom_range(0, 65535));
                kd = 15'($urandom_range(0, 25500));
                dz = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 12));
                if ($urandom_range(0, 1))
                begin
                    fl = 12'($urandom_range(0, 1500));
                    rs = 12'($urandom_range(fl, 2047));
                    es = 12'($urandom_range(2048, 2600));
                    cl = 12'($urandom_range(es, 4095));
                end
                else
                begin
                    fl = 12'($urandom_range(0, 4095));
                    rs = 12'($urandom_range(0, 4095));
                    es = 12'($urandom_range(0, 4095));
                    cl = 12'($urandom_range(0, 4095));
                end
                max_run = int'($urandom_range(1, 20));
            end
        endcase
        run_left = 0;

        junk = 16'($urandom);
        write_reg(pvd_pkg::REG_GAIN_PROP, {junk[7:0], kp});
        write_reg(pvd_pkg::REG_GAIN_INTEG, ki);
        write_reg(pvd_pkg::REG_GAIN_DERIV, {junk[15], kd});
        write_reg(pvd_pkg::REG_RETRACT_START, {junk[3:0], rs});
        write_reg(pvd_pkg::REG_EXTEND_START, {junk[7:4], es});
        write_reg(pvd_pkg::REG_CODE_FLOOR, {junk[11:8], fl});
        write_reg(pvd_pkg::REG_CODE_CEILING, {junk[15:12], cl});
        write_reg(pvd_pkg::REG_DEAD_ZONE, {junk[14:7], dz});
        // index past the register file: must change nothing
        junk = 16'($urandom);
        write_reg(pvd_pkg::CFG_IDX_W'(pvd_pkg::REG_DEAD_ZONE + 1 + $urandom_range(0, 7)), junk);
    endtask

    // Sender: bursts of words with random gaps; predicts each word it hands over
    always @(posedge clk or negedge rst_n)
    begin : feed_ticks
        logic nxt_valid;
        int   burst_left;
        int   gap_left;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                drive_expect.push_back(predict_drive(tick_on_bus));

            if (!s_axis_tvalid || s_axis_tready)
            begin
                nxt_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (tick_queue.size() > 0)
                begin
                    tick_on_bus = tick_queue.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = int'($urandom_range(0, 9));
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            3, 4, 5: gap_left = int'($urandom_range(1, 12));
                            6:       gap_left = int'($urandom_range(13, 60));
                            default: gap_left = int'($urandom_range(61, 140));
                        endcase
                    end
                end
                s_axis_tvalid <= nxt_valid;
                if (nxt_valid)
                    s_axis_tdata <= {{(pvd_pkg::IN_W - $bits(tick_t)){1'b0}}, tick_on_bus};
            end
        end
    end

    // Receiver: checks each word, stalls on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin : take_words
        drive_word_t got;
        drive_word_t want;
        logic [31:0] ready_pattern;
        int          pattern_age;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_pattern = '1;
            pattern_age = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.dac_code = m_axis_tdata[DAC_W-1:0];
                got.loop_active = m_axis_tdata[DAC_W];
                if (drive_expect.size() == 0)
                begin
                    $display("%t unexpected word: expected none, actual 0x%h",
                             $time, m_axis_tdata);
                    fault_count++;
                end
                else
                begin
                    want = drive_expect.pop_front();
                    if (got.dac_code !== want.dac_code)
                    begin
                        $display("%t dac_code mismatch: expected %0d, actual %0d",
                                 $time, want.dac_code, got.dac_code);
                        fault_count++;
                    end
                    if (got.loop_active !== want.loop_active)
                    begin
                        $display("%t loop_active mismatch: expected %0b, actual %0b",
                                 $time, want.loop_active, got.loop_active);
                        fault_count++;
                    end
                end
            end

            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = $urandom;
                    2:       ready_pattern = $urandom | $urandom;
                    default: ready_pattern = $urandom & $urandom;
                endcase
                pattern_age = 97;
            end
            pattern_age--;
            m_axis_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks on the reset register values
        @(negedge clk);
        add_tick(pvd_pkg::DIR_RAISE, 255, 1'b0);
        add_tick(pvd_pkg::DIR_NONE, 255, 1'b1);
        add_tick(pvd_pkg::DIR_NONE, 0, 1'b0);
        add_tick(pvd_pkg::DIR_RAISE, 255, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 3, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 255, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 255, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 3, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 10, 1'b1);
        add_tick(pvd_pkg::DIR_NEUTRAL, 100, 1'b1);
        add_tick(pvd_pkg::DIR_NEUTRAL, 0, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 0, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 1, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 1, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 2, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 2, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 3, 1'b1);
        add_tick(pvd_pkg::DIR_LOWER, 128, 1'b1);
        add_tick(pvd_pkg::DIR_NONE, 170, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 85, 1'b1);
        add_tick(pvd_pkg::DIR_RAISE, 170, 1'b0);
        add_tick(pvd_pkg::DIR_LOWER, 85, 1'b1);
        wait_drained();

        // random phases, registers rewritten while the block is idle
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            setup_phase(ph);
            @(negedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                tick_queue.push_back(make_tick());
            wait_drained();
        end

        // catch any stray word after the last one expected
        repeat (160) @(posedge clk);
        if (drive_expect.size() != 0)
        begin
            $display("%t missing words: expected %0d more, actual 0", $time,
                     drive_expect.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
